// ===== src/hsi_pkg.sv =====
// ----------------------------------------------------------------------------
// HSI to RGB converter package
// Shared types, sector codes, constants and the elaboration-time builder for
// the hue ratio table.
// ----------------------------------------------------------------------------
package hsi_pkg;

  localparam int SAT_FRAC_BITS_DEF   = 8;
  localparam int RATIO_FRAC_BITS_DEF = 14;

  localparam int HUE_MAX     = 361;
  localparam int SEC1_START  = 120;
  localparam int SEC2_START  = 240;
  localparam int OFF_COUNT   = 122;
  localparam int OFF_W       = 7;
  localparam int CH_MAX      = 255;
  localparam int PIPE_STAGES = 7;

  localparam longint ONE_Q30   = 64'sd1073741824;
  localparam longint COS1_Q30  = 64'sd1073578288;
  localparam longint SIN1_Q30  = 64'sd18739379;
  localparam longint SQRT3_Q30 = 64'sd1859775393;
  localparam longint HALF_Q30  = 64'sd536870912;

  typedef enum logic [1:0] {
    SEC_RED   = 2'd0,
    SEC_GREEN = 2'd1,
    SEC_BLUE  = 2'd2
  } sector_t;

  typedef struct packed {
    logic [8:0] hue_deg;
    logic [8:0] saturation;
    logic [7:0] intensity;
  } hsi_in_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } hsi_out_t;

  // Rounds a Q60 product back to Q30, ties away from zero.
  function automatic longint round_q30(input longint v);
    if (v >= 0) begin
      return (v + HALF_Q30) >>> 30;
    end else begin
      return -(((-v) + HALF_Q30) >>> 30);
    end
  endfunction

  // Shift-and-subtract division of two positive values.
  function automatic longint udiv(input longint a, input longint b);
    longint q;
    longint r;
    q = 0;
    r = 0;
    for (int i = 62; i >= 0; i--) begin
      r = (r <<< 1) | ((a >>> i) & 64'sd1);
      if (r >= b) begin
        r = r - b;
        q = q | (64'sd1 <<< i);
      end
    end
    return q;
  endfunction

  function automatic longint div_round(input longint num, input longint den);
    if (num >= 0) begin
      return udiv(2 * num + den, 2 * den);
    end else begin
      return -udiv(2 * (-num) + den, 2 * den);
    end
  endfunction

  // cos(h) / cos(60 - h) in signed Q2.rfb, built by rotating a Q30 unit
  // vector one degree at a time.
  function automatic longint hue_ratio(input int off, input int rfb);
    longint c;
    longint s;
    longint nc;
    longint ns;
    longint d;
    longint q;
    longint lim;
    int     k;
    c = ONE_Q30;
    s = 0;
    for (k = 0; k < off; k++) begin
      nc = round_q30(c * COS1_Q30 - s * SIN1_Q30);
      ns = round_q30(s * COS1_Q30 + c * SIN1_Q30);
      c  = nc;
      s  = ns;
    end
    d = c + round_q30(SQRT3_Q30 * s);
    if (d <= 0) begin
      d = 1;
    end
    q   = div_round(2 * c * (64'sd1 <<< rfb), d);
    lim = 64'sd1 <<< (rfb + 1);
    if (q > lim - 1) begin
      q = lim - 1;
    end
    if (q < -lim) begin
      q = -lim;
    end
    return q;
  endfunction

endpackage

// ===== src/hsi_to_rgb_converter_core.sv =====
// ----------------------------------------------------------------------------
// HSI to RGB converter core
// Three-sector HSI to RGB pixel conversion in a seven-stage pipeline.
//
//   Channel   Direction   Handshake              Payload
//   pix       in          pix_valid/pix_stall    hsi_in_t  (hue, sat, intensity)
//   rgb       out         rgb_valid/rgb_stall    hsi_out_t (red, green, blue)
//
// One pixel enters per clock while pix_stall is low; each accepted item passes
// through the seven register stages in order before its result leaves.
// The seven register stages set the latency; the ratio table read and the
// intensity multiply are the widest single-stage paths.
// Reset clears only the stage valid bits; the block takes items the cycle
// after reset drops.
// An output stall holds the last stage; empty stages still fill, so input
// stall rises only once every stage ahead holds an item.
// ----------------------------------------------------------------------------
module hsi_to_rgb_converter_core import hsi_pkg::*; #(
  parameter int SAT_FRAC_BITS   = SAT_FRAC_BITS_DEF,
  parameter int RATIO_FRAC_BITS = RATIO_FRAC_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     pix_valid,
  output logic     pix_stall,
  input  hsi_in_t  pix,
  output logic     rgb_valid,
  input  logic     rgb_stall,
  output hsi_out_t rgb
);

  localparam int RW = RATIO_FRAC_BITS + 2;
  localparam int DW = ((SAT_FRAC_BITS > 9) ? SAT_FRAC_BITS : 9) + 2;
  localparam int VW = SAT_FRAC_BITS + RATIO_FRAC_BITS + 20;

  logic                 s2m_valid;
  logic                 s2m_stall;
  sector_t              s2m_sec;
  logic signed [RW-1:0] s2m_ratio;
  logic signed [DW-1:0] s2m_diff;
  logic [8:0]           s2m_sat;
  logic [7:0]           s2m_int;

  logic                 m2x_valid;
  logic                 m2x_stall;
  sector_t              m2x_sec;
  logic [7:0]           m2x_int;
  logic signed [VW-1:0] m2x_lead;
  logic signed [VW-1:0] m2x_mn;

  hsi_sector #(
    .SAT_FRAC_BITS  (SAT_FRAC_BITS),
    .RATIO_FRAC_BITS(RATIO_FRAC_BITS)
  ) u_sector (
    .clk      (clk),
    .rst      (rst),
    .pix_valid(pix_valid),
    .pix_stall(pix_stall),
    .pix      (pix),
    .nxt_valid(s2m_valid),
    .nxt_stall(s2m_stall),
    .nxt_sec  (s2m_sec),
    .nxt_ratio(s2m_ratio),
    .nxt_diff (s2m_diff),
    .nxt_sat  (s2m_sat),
    .nxt_int  (s2m_int)
  );

  hsi_mult #(
    .SAT_FRAC_BITS  (SAT_FRAC_BITS),
    .RATIO_FRAC_BITS(RATIO_FRAC_BITS)
  ) u_mult (
    .clk      (clk),
    .rst      (rst),
    .prv_valid(s2m_valid),
    .prv_stall(s2m_stall),
    .prv_sec  (s2m_sec),
    .prv_ratio(s2m_ratio),
    .prv_diff (s2m_diff),
    .prv_sat  (s2m_sat),
    .prv_int  (s2m_int),
    .nxt_valid(m2x_valid),
    .nxt_stall(m2x_stall),
    .nxt_sec  (m2x_sec),
    .nxt_int  (m2x_int),
    .nxt_lead (m2x_lead),
    .nxt_mn   (m2x_mn)
  );

  hsi_mix #(
    .SAT_FRAC_BITS  (SAT_FRAC_BITS),
    .RATIO_FRAC_BITS(RATIO_FRAC_BITS)
  ) u_mix (
    .clk      (clk),
    .rst      (rst),
    .prv_valid(m2x_valid),
    .prv_stall(m2x_stall),
    .prv_sec  (m2x_sec),
    .prv_int  (m2x_int),
    .prv_lead (m2x_lead),
    .prv_mn   (m2x_mn),
    .rgb_valid(rgb_valid),
    .rgb_stall(rgb_stall),
    .rgb      (rgb)
  );

endmodule

// ===== src/hsi_sector.sv =====
// ----------------------------------------------------------------------------
// HSI sector stage
// Clamps the hue, picks the sector and offset, then reads the cosine ratio
// table and forms one minus saturation. Two register stages.
// ----------------------------------------------------------------------------
module hsi_sector import hsi_pkg::*; #(
  parameter int SAT_FRAC_BITS   = SAT_FRAC_BITS_DEF,
  parameter int RATIO_FRAC_BITS = RATIO_FRAC_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   pix_valid,
  output logic                                   pix_stall,
  input  hsi_in_t                                pix,
  output logic                                   nxt_valid,
  input  logic                                   nxt_stall,
  output sector_t                                nxt_sec,
  output logic signed [RATIO_FRAC_BITS+1:0]      nxt_ratio,
  output logic signed [((SAT_FRAC_BITS > 9) ? SAT_FRAC_BITS : 9)+1:0] nxt_diff,
  output logic [8:0]                             nxt_sat,
  output logic [7:0]                             nxt_int
);

  localparam int RW      = RATIO_FRAC_BITS + 2;
  localparam int DW      = ((SAT_FRAC_BITS > 9) ? SAT_FRAC_BITS : 9) + 2;
  localparam int ONE_SAT = 1 << SAT_FRAC_BITS;

  logic signed [RW-1:0] ratio_rom [OFF_COUNT];

  for (genvar g = 0; g < OFF_COUNT; g++) begin : g_rom
    localparam logic signed [RW-1:0] RV = RW'(hue_ratio(g, RATIO_FRAC_BITS));
    assign ratio_rom[g] = RV;
  end

  logic [1:0] vld;
  logic       adv0;
  logic       adv1;

  assign adv1      = !vld[1] || !nxt_stall;
  assign adv0      = !vld[0] || adv1;
  assign pix_stall = !adv0;
  assign nxt_valid = vld[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv0) begin
        vld[0] <= pix_valid;
      end
      if (adv1) begin
        vld[1] <= vld[0];
      end
    end
  end

  logic [8:0]       hue_c;
  sector_t          sec_d;
  logic [OFF_W-1:0] off_d;

  always_comb begin
    hue_c = (pix.hue_deg > 9'(HUE_MAX)) ? 9'(HUE_MAX) : pix.hue_deg;
    if (hue_c < 9'(SEC1_START)) begin
      sec_d = SEC_RED;
      off_d = OFF_W'(hue_c);
    end else if (hue_c < 9'(SEC2_START)) begin
      sec_d = SEC_GREEN;
      off_d = OFF_W'(hue_c - 9'(SEC1_START));
    end else begin
      sec_d = SEC_BLUE;
      off_d = OFF_W'(hue_c - 9'(SEC2_START));
    end
  end

  sector_t          a_sec;
  logic [OFF_W-1:0] a_off;
  logic [8:0]       a_sat;
  logic [7:0]       a_int;

  always_ff @(posedge clk) begin
    if (adv0) begin
      a_sec <= sec_d;
      a_off <= off_d;
      a_sat <= pix.saturation;
      a_int <= pix.intensity;
    end
    if (adv1) begin
      nxt_sec   <= a_sec;
      nxt_ratio <= ratio_rom[a_off];
      nxt_diff  <= $signed(DW'(ONE_SAT)) - $signed(DW'(a_sat));
      nxt_sat   <= a_sat;
      nxt_int   <= a_int;
    end
  end

endmodule

// ===== src/hsi_mult.sv =====
// ----------------------------------------------------------------------------
// HSI product stages
// Forms the leading and minimum channels at full fixed-point scale. Three
// register stages: products, leading term sum, intensity scaling.
// ----------------------------------------------------------------------------
module hsi_mult import hsi_pkg::*; #(
  parameter int SAT_FRAC_BITS   = SAT_FRAC_BITS_DEF,
  parameter int RATIO_FRAC_BITS = RATIO_FRAC_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   prv_valid,
  output logic                                   prv_stall,
  input  sector_t                                prv_sec,
  input  logic signed [RATIO_FRAC_BITS+1:0]      prv_ratio,
  input  logic signed [((SAT_FRAC_BITS > 9) ? SAT_FRAC_BITS : 9)+1:0] prv_diff,
  input  logic [8:0]                             prv_sat,
  input  logic [7:0]                             prv_int,
  output logic                                   nxt_valid,
  input  logic                                   nxt_stall,
  output sector_t                                nxt_sec,
  output logic [7:0]                             nxt_int,
  output logic signed [SAT_FRAC_BITS+RATIO_FRAC_BITS+19:0] nxt_lead,
  output logic signed [SAT_FRAC_BITS+RATIO_FRAC_BITS+19:0] nxt_mn
);

  localparam int F  = SAT_FRAC_BITS + RATIO_FRAC_BITS;
  localparam int RW = RATIO_FRAC_BITS + 2;
  localparam int DW = ((SAT_FRAC_BITS > 9) ? SAT_FRAC_BITS : 9) + 2;
  localparam int PW = RW + 10;
  localparam int MW = DW + 9;
  localparam int LW = ((F > RATIO_FRAC_BITS + 11) ? F : RATIO_FRAC_BITS + 11) + 2;
  localparam int VW = F + 20;
  localparam logic signed [LW-1:0] ONE_FULL = {{(LW-F-1){1'b0}}, 1'b1, {F{1'b0}}};

  logic [2:0] vld;
  logic       adv0;
  logic       adv1;
  logic       adv2;

  assign adv2      = !vld[2] || !nxt_stall;
  assign adv1      = !vld[1] || adv2;
  assign adv0      = !vld[0] || adv1;
  assign prv_stall = !adv0;
  assign nxt_valid = vld[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv0) begin
        vld[0] <= prv_valid;
      end
      if (adv1) begin
        vld[1] <= vld[0];
      end
      if (adv2) begin
        vld[2] <= vld[1];
      end
    end
  end

  sector_t              a_sec;
  logic [7:0]           a_int;
  logic signed [PW-1:0] a_prod;
  logic signed [MW-1:0] a_mn;

  sector_t              b_sec;
  logic [7:0]           b_int;
  logic signed [LW-1:0] b_lt;
  logic signed [MW-1:0] b_mn;

  always_ff @(posedge clk) begin
    if (adv0) begin
      a_sec  <= prv_sec;
      a_int  <= prv_int;
      a_prod <= PW'($signed({1'b0, prv_sat})) * PW'(prv_ratio);
      a_mn   <= MW'($signed({1'b0, prv_int})) * MW'(prv_diff);
    end
    if (adv1) begin
      b_sec <= a_sec;
      b_int <= a_int;
      b_lt  <= ONE_FULL + LW'(a_prod);
      b_mn  <= a_mn;
    end
    if (adv2) begin
      nxt_sec  <= b_sec;
      nxt_int  <= b_int;
      nxt_lead <= VW'($signed({1'b0, b_int})) * VW'(b_lt);
      nxt_mn   <= VW'(b_mn) <<< RATIO_FRAC_BITS;
    end
  end

endmodule

// ===== src/hsi_mix.sv =====
// ----------------------------------------------------------------------------
// HSI channel mix
// Forms the remaining channel from three times the intensity, then clamps
// all three channels and routes them to red, green and blue by sector.
// ----------------------------------------------------------------------------
module hsi_mix import hsi_pkg::*; #(
  parameter int SAT_FRAC_BITS   = SAT_FRAC_BITS_DEF,
  parameter int RATIO_FRAC_BITS = RATIO_FRAC_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   prv_valid,
  output logic                                   prv_stall,
  input  sector_t                                prv_sec,
  input  logic [7:0]                             prv_int,
  input  logic signed [SAT_FRAC_BITS+RATIO_FRAC_BITS+19:0] prv_lead,
  input  logic signed [SAT_FRAC_BITS+RATIO_FRAC_BITS+19:0] prv_mn,
  output logic                                   rgb_valid,
  input  logic                                   rgb_stall,
  output hsi_out_t                               rgb
);

  localparam int F  = SAT_FRAC_BITS + RATIO_FRAC_BITS;
  localparam int VW = F + 20;

  function automatic logic [7:0] to_chan(input logic signed [VW-1:0] v);
    logic signed [VW-1:0] sh;
    sh = v >>> F;
    if (v[VW-1] || v == '0) begin
      return '0;
    end else if (sh > VW'(CH_MAX)) begin
      return 8'(CH_MAX);
    end else begin
      return sh[7:0];
    end
  endfunction

  logic [1:0] vld;
  logic       adv0;
  logic       adv1;

  assign adv1      = !vld[1] || !rgb_stall;
  assign adv0      = !vld[0] || adv1;
  assign prv_stall = !adv0;
  assign rgb_valid = vld[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv0) begin
        vld[0] <= prv_valid;
      end
      if (adv1) begin
        vld[1] <= vld[0];
      end
    end
  end

  logic [9:0]           tri_int;
  sector_t              a_sec;
  logic signed [VW-1:0] a_lead;
  logic signed [VW-1:0] a_mn;
  logic signed [VW-1:0] a_rest;

  assign tri_int = {2'b00, prv_int} + {1'b0, prv_int, 1'b0};

  always_ff @(posedge clk) begin
    if (adv0) begin
      a_sec  <= prv_sec;
      a_lead <= prv_lead;
      a_mn   <= prv_mn;
      a_rest <= (VW'(tri_int) <<< F) - prv_mn - prv_lead;
    end
  end

  logic signed [VW-1:0] r_v;
  logic signed [VW-1:0] g_v;
  logic signed [VW-1:0] b_v;

  always_comb begin
    case (a_sec)
      SEC_RED: begin
        r_v = a_lead;
        g_v = a_rest;
        b_v = a_mn;
      end
      SEC_GREEN: begin
        r_v = a_mn;
        g_v = a_lead;
        b_v = a_rest;
      end
      SEC_BLUE: begin
        r_v = a_rest;
        g_v = a_mn;
        b_v = a_lead;
      end
      default: begin
        r_v = '0;
        g_v = '0;
        b_v = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      rgb.red   <= to_chan(r_v);
      rgb.green <= to_chan(g_v);
      rgb.blue  <= to_chan(b_v);
    end
  end

endmodule

// ===== src/hsi_checker.sv =====
// ----------------------------------------------------------------------------
// HSI converter port checker
// Tracks items in flight from the ports and checks occupancy, stall and
// reset behavior of the pipeline.
// ----------------------------------------------------------------------------
module hsi_checker import hsi_pkg::*; (
  input logic     clk,
  input logic     rst,
  input logic     pix_valid,
  input logic     pix_stall,
  input logic     rgb_valid,
  input logic     rgb_stall,
  input hsi_out_t rgb
);

  logic [3:0] cnt;
  logic [3:0] cnt_next;
  logic       acc_in;
  logic       acc_out;

  assign acc_in   = pix_valid && !pix_stall;
  assign acc_out  = rgb_valid && !rgb_stall;
  assign cnt_next = cnt + 4'(acc_in) - 4'(acc_out);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      cnt <= cnt_next;
    end
  end

  // The pipeline never holds more items than it has stages.
  a_depth: assert property (@(posedge clk) disable iff (rst)
    cnt <= 4'(PIPE_STAGES))
    else $error("more items in flight than pipeline stages");

  // A result can only appear for an item that was accepted.
  a_no_invent: assert property (@(posedge clk) disable iff (rst)
    rgb_valid |-> cnt != '0)
    else $error("result shown with no item in flight");

  // With the output stage empty, nothing ahead can block the input.
  a_no_idle_stall: assert property (@(posedge clk) disable iff (rst)
    !rgb_valid |-> !pix_stall)
    else $error("input stalled while output stage is empty");

  a_rgb_hold: assert property (@(posedge clk) disable iff (rst)
    rgb_valid && rgb_stall |=> rgb_valid && $stable(rgb))
    else $error("stalled result changed or dropped");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !rgb_valid)
    else $error("result valid right after reset");

endmodule

bind hsi_to_rgb_converter_core hsi_checker u_hsi_checker (.*);
